@@ hw/rtl/wspid_pkg.sv @@
`timescale 1ns / 1ps

package wspid_pkg;

	// Internal word: signed Q16.16.
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 16;
	localparam int SETPOINT_W = 24;
	localparam int SPEED_W    = 24;
	localparam int DUTY_W     = 27;

	// Multiplier operands: magnitude of a word times an unsigned gain.
	localparam int GAIN_W = 24;
	localparam int PROD_W = WORD_W + GAIN_W;

	// Fraction bits dropped after a gain product and after the speed product.
	localparam int Q_SHIFT     = 16;
	localparam int SPEED_SHIFT = 8;

	localparam int ALPHA_W = 17;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 27;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN     = 4'd0,
		CFG_INT_GAIN      = 4'd1,
		CFG_DERIV_GAIN    = 4'd2,
		CFG_BACKCALC_GAIN = 4'd3,
		CFG_FILTER_ALPHA  = 4'd4,
		CFG_OUTPUT_LIMIT  = 4'd5,
		CFG_INT_LIMIT     = 4'd6,
		CFG_SPEED_SCALE   = 4'd7
	} cfg_idx_t;

	localparam logic [23:0] RST_PROP_GAIN     = 24'd131072;
	localparam logic [23:0] RST_INT_GAIN      = 24'd19661;
	localparam logic [23:0] RST_DERIV_GAIN    = 24'd655;
	localparam logic [23:0] RST_BACKCALC_GAIN = 24'd0;
	localparam logic [16:0] RST_FILTER_ALPHA  = 17'd65536;
	localparam logic [26:0] RST_OUTPUT_LIMIT  = 27'd26214400;
	localparam logic [26:0] RST_INT_LIMIT     = 27'd26214400;
	localparam logic [23:0] RST_SPEED_SCALE   = 24'd845180;

	// Operand set handed to the shared multiplier.
	typedef struct packed {
		logic              en;
		logic              neg;
		logic [WORD_W-1:0] mag;
		logic [GAIN_W-1:0] gain;
	} mul_req_t;

endpackage

@@ hw/rtl/wspid_if.sv @@
`timescale 1ns / 1ps

interface wspid_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [wspid_pkg::SETPOINT_W-1:0] setpoint_speed;
	logic signed [wspid_pkg::COUNT_W-1:0]    pulse_count;

	modport source (output valid, output setpoint_speed, output pulse_count, input ready);
	modport sink (input valid, input setpoint_speed, input pulse_count, output ready);
endinterface

interface wspid_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [wspid_pkg::DUTY_W-1:0]         duty;
	logic signed [wspid_pkg::SPEED_W-1:0] measured_speed;
	logic                                 output_saturated;

	modport source (output valid, output duty, output measured_speed,
		output output_saturated, input ready);
	modport sink (input valid, input duty, input measured_speed,
		input output_saturated, output ready);
endinterface

interface wspid_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wspid_pkg::CFG_IDX_W-1:0]  index;
	logic [wspid_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/wspid_mul.sv @@
`timescale 1ns / 1ps

module wspid_mul (
	input  logic                         clk,
	input  wspid_pkg::mul_req_t          req,
	output logic [wspid_pkg::PROD_W-1:0] prod_q,
	output logic                         neg_q
);
	import wspid_pkg::*;

	// Unsigned magnitude product; the sign travels alongside and is applied
	// by the consumer after the fraction bits are dropped.
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.mag) * PROD_W'(req.gain);
			neg_q  <= req.neg;
		end
	end

endmodule

@@ hw/rtl/wheel_speed_pid_antiwindup_unit.sv @@
`timescale 1ns / 1ps
// The sequencer runs seven products through one shared 32 x 24 multiplier and
// holds the input ready low while it works; a new item is taken only after the
// last one has been loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) restores the register defaults and clears the
// controller state and the output valid.
module wheel_speed_pid_antiwindup_unit (
	input logic        clk,
	input logic        arst_n,
	wspid_in_if.sink   sample,
	wspid_out_if.source result,
	wspid_cfg_if.sink  cfg_wr
);
	import wspid_pkg::*;

	localparam int SV_W   = PROD_W + 1;
	localparam int WIDE_W = PROD_W + 2;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_SPEED = 13'b0000000000010,
		ST_MEAS  = 13'b0000000000100,
		ST_ERR   = 13'b0000000001000,
		ST_DIFF  = 13'b0000000010000,
		ST_P     = 13'b0000000100000,
		ST_D     = 13'b0000001000000,
		ST_KI    = 13'b0000010000000,
		ST_KB    = 13'b0000100000000,
		ST_A     = 13'b0001000000000,
		ST_B     = 13'b0010000000000,
		ST_PID   = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'({1'b0, {(WORD_W-1){1'b1}}});
		lo = -hi - WIDE_W'(1);
		if (v > hi) return hi[WORD_W-1:0];
		if (v < lo) return lo[WORD_W-1:0];
		return v[WORD_W-1:0];
	endfunction

	function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [SV_W-1:0] v);
		logic signed [SV_W-1:0] hi;
		logic signed [SV_W-1:0] lo;
		hi = SV_W'({1'b0, {(SPEED_W-1){1'b1}}});
		lo = -hi - SV_W'(1);
		if (v > hi) return hi[SPEED_W-1:0];
		if (v < lo) return lo[SPEED_W-1:0];
		return v[SPEED_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] mag_word(input logic signed [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	state_t state_q;

	logic [23:0] prop_gain_q, int_gain_q, deriv_gain_q, backcalc_gain_q, speed_scale_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [DUTY_W-1:0]  out_limit_q, int_limit_q;

	logic signed [SETPOINT_W-1:0] setpoint_q;
	logic signed [COUNT_W-1:0]    pulse_q;
	logic signed [SPEED_W-1:0]    measured_q;
	logic signed [WORD_W-1:0]     err_q, diff_q, p_q, d_q, pid_q;
	logic signed [WIDE_W-1:0]     acc_q;
	logic signed [SV_W-1:0]       m1_q;

	logic signed [WORD_W-1:0] prev_err_q, integ_q, pfd_q, excess_q;

	logic                     out_valid_q;
	logic [DUTY_W-1:0]        duty_q;
	logic signed [SPEED_W-1:0] meas_out_q;
	logic                     clipped_q;

	mul_req_t          mreq;
	logic [PROD_W-1:0] prod_q;
	logic              prod_neg_q;

	logic [ALPHA_W-1:0]       alpha_eff;
	logic [PROD_W-1:0]        shifted;
	logic signed [SV_W-1:0]   sv;
	logic signed [WORD_W-1:0] sv_sat;
	logic signed [WORD_W-1:0] i_sat, i_clamped, df_sat, duty_w, excess_w;
	logic signed [WORD_W-1:0] olim_w, ilim_w;
	logic                     out_free, clip_hi, clip_lo;

	wspid_mul u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_q (prod_q),
		.neg_q  (prod_neg_q)
	);

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign olim_w    = WORD_W'(out_limit_q);
	assign ilim_w    = WORD_W'(int_limit_q);

	// Drop the fraction bits, then restore the sign.
	assign shifted = (state_q == ST_MEAS) ? (prod_q >> SPEED_SHIFT) : (prod_q >> Q_SHIFT);
	assign sv      = prod_neg_q ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
	assign sv_sat  = sat_word(WIDE_W'(sv));

	assign i_sat     = sat_word(acc_q + WIDE_W'(sv_sat));
	assign i_clamped = (i_sat > ilim_w) ? ilim_w : ((i_sat < 0) ? '0 : i_sat);
	assign df_sat    = sat_word(WIDE_W'(m1_q) + WIDE_W'(sv));

	assign clip_hi  = pid_q > olim_w;
	assign clip_lo  = pid_q < 0;
	assign duty_w   = clip_hi ? olim_w : (clip_lo ? '0 : pid_q);
	assign excess_w = sat_word(WIDE_W'(duty_w) - WIDE_W'(pid_q));
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		mreq.en   = 1'b1;
		mreq.mag  = mag_word(err_q);
		mreq.gain = prop_gain_q;
		unique case (state_q)
			ST_SPEED: begin
				mreq.mag  = mag_word(WORD_W'(pulse_q));
				mreq.gain = speed_scale_q;
			end
			ST_DIFF: begin
				mreq.mag  = mag_word(err_q);
				mreq.gain = prop_gain_q;
			end
			ST_P: begin
				mreq.mag  = mag_word(diff_q);
				mreq.gain = deriv_gain_q;
			end
			ST_D: begin
				mreq.mag  = mag_word(err_q);
				mreq.gain = int_gain_q;
			end
			ST_KI: begin
				mreq.mag  = mag_word(excess_q);
				mreq.gain = backcalc_gain_q;
			end
			ST_KB: begin
				mreq.mag  = mag_word(d_q);
				mreq.gain = GAIN_W'(alpha_eff);
			end
			ST_A: begin
				mreq.mag  = mag_word(pfd_q);
				mreq.gain = GAIN_W'(ALPHA_ONE - alpha_eff);
			end
			default: begin
				mreq.en = 1'b0;
			end
		endcase
		mreq.neg = mreq.mag != '0 && (
			(state_q == ST_SPEED) ? pulse_q[COUNT_W-1] :
			(state_q == ST_P)     ? diff_q[WORD_W-1] :
			(state_q == ST_KI)    ? excess_q[WORD_W-1] :
			(state_q == ST_KB)    ? d_q[WORD_W-1] :
			(state_q == ST_A)     ? pfd_q[WORD_W-1] : err_q[WORD_W-1]);
	end

	assign sample.ready = state_q == ST_IDLE;
	assign cfg_wr.ready = 1'b1;

	assign result.valid            = out_valid_q;
	assign result.duty             = duty_q;
	assign result.measured_speed   = meas_out_q;
	assign result.output_saturated = clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= RST_PROP_GAIN;
			int_gain_q      <= RST_INT_GAIN;
			deriv_gain_q    <= RST_DERIV_GAIN;
			backcalc_gain_q <= RST_BACKCALC_GAIN;
			alpha_q         <= RST_FILTER_ALPHA;
			out_limit_q     <= RST_OUTPUT_LIMIT;
			int_limit_q     <= RST_INT_LIMIT;
			speed_scale_q   <= RST_SPEED_SCALE;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				CFG_PROP_GAIN:     prop_gain_q     <= cfg_wr.data[23:0];
				CFG_INT_GAIN:      int_gain_q      <= cfg_wr.data[23:0];
				CFG_DERIV_GAIN:    deriv_gain_q    <= cfg_wr.data[23:0];
				CFG_BACKCALC_GAIN: backcalc_gain_q <= cfg_wr.data[23:0];
				CFG_FILTER_ALPHA:  alpha_q         <= cfg_wr.data[ALPHA_W-1:0];
				CFG_OUTPUT_LIMIT:  out_limit_q     <= cfg_wr.data[DUTY_W-1:0];
				CFG_INT_LIMIT:     int_limit_q     <= cfg_wr.data[DUTY_W-1:0];
				CFG_SPEED_SCALE:   speed_scale_q   <= cfg_wr.data[23:0];
				default: begin
					// Writes to unknown indexes are dropped.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_err_q  <= '0;
			integ_q     <= '0;
			pfd_q       <= '0;
			excess_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (sample.valid) state_q <= ST_SPEED;
				ST_SPEED: state_q <= ST_MEAS;
				ST_MEAS:  state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_P;
				ST_P:     state_q <= ST_D;
				ST_D:     state_q <= ST_KI;
				ST_KI:    state_q <= ST_KB;
				ST_KB: begin
					integ_q <= i_clamped;
					state_q <= ST_A;
				end
				ST_A:     state_q <= ST_B;
				ST_B: begin
					pfd_q      <= df_sat;
					prev_err_q <= err_q;
					state_q    <= ST_PID;
				end
				ST_PID:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						excess_q <= excess_w;
						state_q  <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; only the sequencer decides when they matter.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				setpoint_q <= sample.setpoint_speed;
				pulse_q    <= sample.pulse_count;
			end
			ST_MEAS: measured_q <= sat_speed(sv);
			ST_ERR:  err_q <= sat_word(WIDE_W'(setpoint_q) - WIDE_W'(measured_q));
			ST_DIFF: diff_q <= sat_word(WIDE_W'(err_q) - WIDE_W'(prev_err_q));
			ST_P:    p_q <= sv_sat;
			ST_D:    d_q <= sv_sat;
			ST_KI:   acc_q <= WIDE_W'(integ_q) + WIDE_W'(sv_sat);
			ST_A:    m1_q <= sv;
			ST_PID:  pid_q <= sat_word(WIDE_W'(p_q) + WIDE_W'(pfd_q) + WIDE_W'(integ_q));
			ST_OUT: begin
				if (out_free) begin
					duty_q     <= duty_w[DUTY_W-1:0];
					meas_out_q <= measured_q;
					clipped_q  <= clip_hi || clip_lo;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/wspid_checker.sv @@
`timescale 1ns / 1ps

module wspid_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [wspid_pkg::DUTY_W-1:0]         duty,
	input logic signed [wspid_pkg::SPEED_W-1:0] measured_speed,
	input logic                                 output_saturated
);
	import wspid_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(duty) && $stable(measured_speed)
			&& $stable(output_saturated))
		else $error("stalled result changed");

	// The sequencer is busy for a stretch after each input transfer.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input taken while an item is in progress");

	// An input transfer made while no result is offered does not bring a result out at once.
	a_no_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid ##1 !out_valid)
		else $error("result appeared too early");

endmodule

bind wheel_speed_pid_antiwindup_unit wspid_checker u_wspid_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.duty             (result.duty),
	.measured_speed   (result.measured_speed),
	.output_saturated (result.output_saturated)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import wspid_pkg::*;

	localparam int N_REGS = 8;
	localparam longint Q_ONE = 64'sd65536;
	localparam int LIMIT_NS = 5_000_000;

	localparam logic signed [SETPOINT_W-1:0] SP_MAX = {1'b0, {(SETPOINT_W-1){1'b1}}};
	localparam logic signed [SETPOINT_W-1:0] SP_MIN = {1'b1, {(SETPOINT_W-1){1'b0}}};
	localparam logic signed [COUNT_W-1:0]    PC_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
	localparam logic signed [COUNT_W-1:0]    PC_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

	typedef logic [CFG_DATA_W-1:0] reg_set_t [N_REGS];

	typedef struct packed {
		logic [DUTY_W-1:0]         duty;
		logic signed [SPEED_W-1:0] speed;
		logic                      saturated;
	} pwm_result_t;

	typedef enum {RX_OPEN, RX_SPARSE, RX_RARE, RX_BLOCKS} rx_mode_t;

	class speed_loop_model;
		logic [CFG_DATA_W-1:0] regs [N_REGS];
		longint prev_error;
		longint integ;
		longint prev_dfilt;
		longint excess;
		pwm_result_t pending_outputs [$];
		int mismatches;

		function new();
			regs[CFG_PROP_GAIN]     = CFG_DATA_W'(RST_PROP_GAIN);
			regs[CFG_INT_GAIN]      = CFG_DATA_W'(RST_INT_GAIN);
			regs[CFG_DERIV_GAIN]    = CFG_DATA_W'(RST_DERIV_GAIN);
			regs[CFG_BACKCALC_GAIN] = CFG_DATA_W'(RST_BACKCALC_GAIN);
			regs[CFG_FILTER_ALPHA]  = CFG_DATA_W'(RST_FILTER_ALPHA);
			regs[CFG_OUTPUT_LIMIT]  = CFG_DATA_W'(RST_OUTPUT_LIMIT);
			regs[CFG_INT_LIMIT]     = CFG_DATA_W'(RST_INT_LIMIT);
			regs[CFG_SPEED_SCALE]   = CFG_DATA_W'(RST_SPEED_SCALE);
			prev_error = 0;
			integ = 0;
			prev_dfilt = 0;
			excess = 0;
			mismatches = 0;
		endfunction

		static function longint clip(longint v, int w);
			longint hi;
			hi = (longint'(1) << (w - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		// Q16.16 value times an unsigned gain, fraction dropped toward zero.
		static function longint gain_mul(longint a, longint g);
			longint m;
			longint r;
			m = (a < 0) ? -a : a;
			r = (m >> Q_SHIFT) * g + (((m & 64'hFFFF) * g) >> Q_SHIFT);
			return (a < 0) ? -r : r;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PROP_GAIN, CFG_INT_GAIN, CFG_DERIV_GAIN, CFG_BACKCALC_GAIN,
				CFG_SPEED_SCALE: begin
					regs[idx] = CFG_DATA_W'(data[GAIN_W-1:0]);
				end
				CFG_FILTER_ALPHA: begin
					regs[idx] = CFG_DATA_W'(data[ALPHA_W-1:0]);
				end
				CFG_OUTPUT_LIMIT, CFG_INT_LIMIT: begin
					regs[idx] = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void take_sample(logic signed [SETPOINT_W-1:0] sp,
				logic signed [COUNT_W-1:0] pc);
			longint alpha, olim, ilim, mag, speed, err, p, d, df, i, pid, duty;
			pwm_result_t r;
			alpha = (regs[CFG_FILTER_ALPHA] > Q_ONE) ? Q_ONE : longint'(regs[CFG_FILTER_ALPHA]);
			olim = longint'(regs[CFG_OUTPUT_LIMIT]);
			ilim = longint'(regs[CFG_INT_LIMIT]);
			mag = (pc < 0) ? -longint'(pc) : longint'(pc);
			speed = (mag * longint'(regs[CFG_SPEED_SCALE])) >> SPEED_SHIFT;
			speed = clip((pc < 0) ? -speed : speed, SPEED_W);
			err = clip(longint'(sp) - speed, WORD_W);
			p = clip(gain_mul(err, regs[CFG_PROP_GAIN]), WORD_W);
			d = clip(gain_mul(clip(err - prev_error, WORD_W), regs[CFG_DERIV_GAIN]), WORD_W);
			df = clip(gain_mul(d, alpha) + gain_mul(prev_dfilt, Q_ONE - alpha), WORD_W);
			i = clip(integ + clip(gain_mul(err, regs[CFG_INT_GAIN]), WORD_W) +
				clip(gain_mul(excess, regs[CFG_BACKCALC_GAIN]), WORD_W), WORD_W);
			if (i > ilim)
				i = ilim;
			if (i < 0)
				i = 0;
			integ = i;
			prev_error = err;
			prev_dfilt = df;
			pid = clip(p + df + i, WORD_W);
			r.saturated = (pid > olim) || (pid < 0);
			duty = (pid > olim) ? olim : ((pid < 0) ? 0 : pid);
			excess = clip(duty - pid, WORD_W);
			r.duty = DUTY_W'(duty);
			r.speed = SPEED_W'(speed);
			pending_outputs.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task match_output(logic [DUTY_W-1:0] duty, logic signed [SPEED_W-1:0] speed,
				logic saturated);
			pwm_result_t want;
			if (pending_outputs.size() == 0) begin
				report($sformatf("result transfer with no sample pending, duty %0d", duty));
				return;
			end
			want = pending_outputs.pop_front();
			if (duty !== want.duty)
				report($sformatf("duty %0d, expected %0d", duty, want.duty));
			if (speed !== want.speed)
				report($sformatf("measured_speed %0d, expected %0d", speed, want.speed));
			if (saturated !== want.saturated)
				report($sformatf("output_saturated %b, expected %b", saturated, want.saturated));
		endtask
	endclass

	logic clk;
	logic arst_n;

	wspid_in_if  sample_bus();
	wspid_out_if result_bus();
	wspid_cfg_if cfg_bus();

	speed_loop_model model = new();

	wheel_speed_pid_antiwindup_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus),
		.cfg_wr (cfg_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#(LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			model.match_output(result_bus.duty, result_bus.measured_speed,
				result_bus.output_saturated);
	end

	// The receiver switches between stall patterns after runs of random length.
	initial begin : sink_side
		rx_mode_t mode;
		int run;
		int left;
		result_bus.ready = 1'b0;
		mode = RX_OPEN;
		run = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				mode = rx_mode_t'($urandom_range(3));
				run = $urandom_range(300, 40);
			end
			run--;
			case (mode)
				RX_OPEN: result_bus.ready <= 1'b1;
				RX_SPARSE: result_bus.ready <= ($urandom_range(3) != 0);
				RX_RARE: result_bus.ready <= ($urandom_range(7) == 0);
				default: begin
					if (left > 0) begin
						left--;
						result_bus.ready <= 1'b0;
					end else begin
						left = $urandom_range(25);
						result_bus.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Drops the sample valid and returns at a falling edge once every result is in.
	task automatic settle();
		sample_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (model.pending_outputs.size() != 0);
	endtask

	task automatic send_sample(input logic signed [SETPOINT_W-1:0] sp,
			input logic signed [COUNT_W-1:0] pc);
		sample_bus.valid <= 1'b1;
		sample_bus.setpoint_speed <= sp;
		sample_bus.pulse_count <= pc;
		do
			@(posedge clk);
		while (!sample_bus.ready);
		model.take_sample(sp, pc);
		@(negedge clk);
	endtask

	task automatic apply_settings(input reg_set_t vals);
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		settle();
		cfg_bus.valid <= 1'b1;
		// The first transfer goes to an unused index and must change nothing.
		for (int k = -1; k < N_REGS; k++) begin
			if (k < 0) begin
				idx = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_SPEED_SCALE + 1));
				data = CFG_DATA_W'($urandom);
			end else begin
				idx = CFG_IDX_W'(k);
				data = vals[k];
			end
			cfg_bus.index <= idx;
			cfg_bus.data <= data;
			do
				@(posedge clk);
			while (!cfg_bus.ready);
			model.write_reg(idx, data);
			@(negedge clk);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_extremes();
		logic signed [SETPOINT_W-1:0] sps [10] = '{0, SP_MAX, SP_MIN, 0, 0,
			SP_MAX, SP_MIN, SP_MAX, -1, SP_MIN};
		logic signed [COUNT_W-1:0] pcs [10] = '{0, 0, 0, PC_MAX, PC_MIN,
			PC_MIN, PC_MAX, PC_MAX, 1, PC_MIN};
		for (int k = 0; k < 10; k++)
			send_sample(sps[k], pcs[k]);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_gain();
		case ($urandom_range(3))
			0: return CFG_DATA_W'($urandom_range(1 << 16));
			1: return CFG_DATA_W'($urandom_range(1 << 19));
			2: return CFG_DATA_W'($urandom_range(1 << 12));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic reg_set_t rand_settings();
		reg_set_t s;
		s[CFG_PROP_GAIN] = rand_gain();
		s[CFG_INT_GAIN] = rand_gain();
		s[CFG_DERIV_GAIN] = rand_gain();
		s[CFG_BACKCALC_GAIN] = rand_gain();
		s[CFG_FILTER_ALPHA] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) :
			CFG_DATA_W'($urandom_range(65536));
		s[CFG_OUTPUT_LIMIT] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) :
			CFG_DATA_W'($urandom_range(1 << 26));
		s[CFG_INT_LIMIT] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) :
			CFG_DATA_W'($urandom_range(1 << 26));
		s[CFG_SPEED_SCALE] = ($urandom_range(1) == 0) ? CFG_DATA_W'($urandom_range(2000000)) :
			CFG_DATA_W'($urandom);
		return s;
	endfunction

	// Mostly a tracking loop: a setpoint held for a while with pulse counts near the
	// matching speed, mixed with fully random and extreme samples.
	task automatic drive_phase(input int n);
		int burst;
		int gap;
		int held;
		int hold_off_at;
		longint track;
		longint scale;
		logic signed [SETPOINT_W-1:0] hold_sp;
		logic signed [SETPOINT_W-1:0] sp;
		logic signed [COUNT_W-1:0] pc;
		burst = $urandom_range(30, 1);
		held = 0;
		hold_sp = '0;
		hold_off_at = $urandom_range(n - 1);
		for (int k = 0; k < n; k++) begin
			if (k == hold_off_at)
				settle();
			case ($urandom_range(9))
				0, 1: begin
					sp = SETPOINT_W'($urandom);
					pc = COUNT_W'($urandom);
				end
				2: begin
					case ($urandom_range(3))
						0: sp = SP_MAX;
						1: sp = SP_MIN;
						2: sp = '0;
						default: sp = '1;
					endcase
					case ($urandom_range(3))
						0: pc = PC_MAX;
						1: pc = PC_MIN;
						2: pc = '0;
						default: pc = '1;
					endcase
				end
				default: begin
					if (held == 0) begin
						hold_sp = SETPOINT_W'($urandom);
						hold_sp = hold_sp >>> $urandom_range(12);
						held = $urandom_range(40, 5);
					end
					held--;
					scale = longint'(model.regs[CFG_SPEED_SCALE]);
					track = (scale == 0) ? 0 :
						(longint'(hold_sp) * (longint'(1) << SPEED_SHIFT)) / scale;
					track = track + longint'($urandom_range(16)) - 8;
					if (track > PC_MAX)
						track = PC_MAX;
					if (track < PC_MIN)
						track = PC_MIN;
					sp = hold_sp;
					pc = COUNT_W'(track);
				end
			endcase
			send_sample(sp, pc);
			burst--;
			if (burst <= 0) begin
				burst = $urandom_range(30, 1);
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
				if (gap > 0) begin
					sample_bus.valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	endtask

	initial begin : stimulus
		reg_set_t s;
		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.setpoint_speed = '0;
		sample_bus.pulse_count = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_extremes();
		drive_phase(123);

		s = '{default: '0};
		apply_settings(s);
		drive_phase(123);

		// All ones: alpha above one and wide values truncated.
		s = '{default: '1};
		apply_settings(s);
		send_extremes();
		drive_phase(123);

		s[CFG_PROP_GAIN] = CFG_DATA_W'(24'hFFFFFF);
		s[CFG_INT_GAIN] = CFG_DATA_W'(24'hFFFFFF);
		s[CFG_DERIV_GAIN] = CFG_DATA_W'(24'hFFFFFF);
		s[CFG_BACKCALC_GAIN] = CFG_DATA_W'(24'hFFFFFF);
		s[CFG_FILTER_ALPHA] = CFG_DATA_W'(ALPHA_ONE);
		s[CFG_OUTPUT_LIMIT] = CFG_DATA_W'(1 << 26);
		s[CFG_INT_LIMIT] = CFG_DATA_W'(1 << 26);
		s[CFG_SPEED_SCALE] = CFG_DATA_W'(24'hFFFFFF);
		apply_settings(s);
		drive_phase(123);

		s[CFG_PROP_GAIN] = CFG_DATA_W'(RST_PROP_GAIN);
		s[CFG_INT_GAIN] = CFG_DATA_W'(RST_INT_GAIN);
		s[CFG_DERIV_GAIN] = CFG_DATA_W'(RST_DERIV_GAIN);
		s[CFG_BACKCALC_GAIN] = CFG_DATA_W'(32768);
		s[CFG_FILTER_ALPHA] = CFG_DATA_W'(19661);
		s[CFG_OUTPUT_LIMIT] = CFG_DATA_W'(RST_OUTPUT_LIMIT);
		s[CFG_INT_LIMIT] = CFG_DATA_W'(13107200);
		s[CFG_SPEED_SCALE] = CFG_DATA_W'(RST_SPEED_SCALE);
		apply_settings(s);
		drive_phase(123);

		repeat (5) begin
			apply_settings(rand_settings());
			drive_phase(123);
		end

		settle();
		repeat (30) @(posedge clk);
		if (model.mismatches == 0 && model.pending_outputs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/wspid_pkg.sv
hw/rtl/wspid_if.sv
hw/rtl/wspid_mul.sv
hw/rtl/wheel_speed_pid_antiwindup_unit.sv
hw/rtl/wspid_checker.sv
bench/tb.sv
